// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, evaluated at every rising edge outside reset.
`define SRTF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication into the following cycle.
`define SRTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/srtf_pkg.sv -----
// Shared types and constants of the SRTF scheduler.
// No dependencies; imported by the table, the minimum unit and the top level.
package srtf_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    RPT_ACCEPT  = 3'd0,
    RPT_REJECT  = 3'd1,
    RPT_IDLE    = 3'd2,
    RPT_PREEMPT = 3'd3,
    RPT_RAN     = 3'd4
  } rpt_kind_e;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Write request to the job table.
  typedef struct packed {
    logic job_we;  // new job: all three fields
    logic rem_we;  // remaining time only
  } tbl_wr_t;

  // Running result of the minimum search.
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] best;
  } min_stat_t;

endpackage

// ----- hdl/srtf_preemptive_scheduler.sv -----
// Shortest-remaining-time-first scheduler: an arrival is taken and answered in the
// next cycle; a tick with jobs loaded stays busy while it scans every loaded slot,
// drains, decides and finishes (no finish if all loaded jobs are done, and busy
// stays low if no job was ever loaded). The scan uses the single read port of the
// job table, which a shared compare unit walks one slot per cycle. Results appear
// on strobe for one cycle each and cannot be held off; a preemption gives two
// results on consecutive cycles, the second with last_report_o set.
// Depends on srtf_pkg, srtf_table, srtf_min_unit and assert_macros.svh.
`include "assert_macros.svh"

module srtf_preemptive_scheduler import srtf_pkg::*; #(
  parameter int unsigned MAX_JOBS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              kind_i,
  input  logic [TIME_W-1:0] burst_length_i,
  output logic              strobe,
  output logic [KIND_W-1:0] report_kind_o,
  output logic [SLOT_W-1:0] job_slot_o,
  output logic              segment_closed_o,
  output logic [TIME_W-1:0] segment_start_o,
  output logic [TIME_W-1:0] segment_finish_o,
  output logic              job_done_o,
  output logic [TIME_W-1:0] turnaround_o,
  output logic [TIME_W-1:0] waiting_o,
  output logic [TIME_W-1:0] finish_time_o,
  output logic              last_report_o
);

  localparam int unsigned AW = $clog2(MAX_JOBS);
  localparam int unsigned LW = $clog2(MAX_JOBS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [TIME_W-1:0] now_q;
  logic [LW-1:0]     loaded_q;
  logic              run_valid_q;
  logic [AW-1:0]     run_slot_q;
  logic [TIME_W-1:0] seg_begin_q;
  logic [AW-1:0]     scan_idx_q;
  logic              feed_q;
  logic [AW-1:0]     feed_idx_q;

  logic              strobe_q;
  rpt_kind_e         kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic              closed_q;
  logic [TIME_W-1:0] start_q;
  logic [TIME_W-1:0] fin_q;
  logic              done_q;
  logic [TIME_W-1:0] tat_q;
  logic [TIME_W-1:0] wt_q;
  logic [TIME_W-1:0] ft_q;
  logic              last_q;

  logic              accept;
  logic              table_full;
  logic              scan_last;
  logic [TIME_W-1:0] now_inc;
  logic [TIME_W-1:0] rem_new;
  logic [TIME_W-1:0] tat;
  logic [TIME_W-1:0] wt;

  tbl_wr_t           tbl_wr;
  logic [AW-1:0]     tbl_wr_addr;
  logic [TIME_W-1:0] tbl_wr_rem;
  logic [AW-1:0]     tbl_rd_addr;
  logic [TIME_W-1:0] rd_rem, rd_arr, rd_bur;

  min_stat_t         min_stat;
  logic [AW-1:0]     min_sel;
  logic              min_clear;

  assign accept     = start && !busy;
  assign busy       = (state_q != ST_IDLE);
  assign table_full = (loaded_q == LW'(MAX_JOBS));
  assign scan_last  = ((LW'(scan_idx_q) + LW'(1)) == loaded_q);
  assign now_inc    = now_q + TIME_W'(1);
  assign rem_new    = min_stat.best - TIME_W'(1);
  assign tat        = now_inc - rd_arr;
  assign wt         = tat - rd_bur;
  assign min_clear  = accept && (kind_i == KIND_TICK);

  always_comb begin
    tbl_wr        = '0;
    tbl_wr_addr   = min_sel;
    tbl_wr_rem    = rem_new;
    if (accept && (kind_i == KIND_ARRIVE) && (burst_length_i != '0) && !table_full) begin
      tbl_wr.job_we = 1'b1;
      tbl_wr_addr   = loaded_q[AW-1:0];
      tbl_wr_rem    = burst_length_i;
    end else if (state_q == ST_FINISH) begin
      tbl_wr.rem_we = 1'b1;
    end
  end

  assign tbl_rd_addr = (state_q == ST_SCAN) ? scan_idx_q : min_sel;

  srtf_table #(
    .DEPTH(MAX_JOBS),
    .AW   (AW)
  ) u_table (
    .clk_i    (clk_i),
    .wr_i     (tbl_wr),
    .wr_addr_i(tbl_wr_addr),
    .wr_rem_i (tbl_wr_rem),
    .wr_arr_i (now_q),
    .wr_bur_i (burst_length_i),
    .rd_addr_i(tbl_rd_addr),
    .rd_rem_o (rd_rem),
    .rd_arr_o (rd_arr),
    .rd_bur_o (rd_bur)
  );

  srtf_min_unit #(
    .AW(AW)
  ) u_min (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(min_clear),
    .feed_i (feed_q),
    .rem_i  (rd_rem),
    .idx_i  (feed_idx_q),
    .stat_o (min_stat),
    .sel_o  (min_sel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      loaded_q    <= '0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      seg_begin_q <= '0;
      scan_idx_q  <= '0;
      feed_q      <= 1'b0;
      feed_idx_q  <= '0;
      strobe_q    <= 1'b0;
      kind_q      <= RPT_ACCEPT;
      slot_q      <= '0;
      closed_q    <= 1'b0;
      start_q     <= '0;
      fin_q       <= '0;
      done_q      <= 1'b0;
      tat_q       <= '0;
      wt_q        <= '0;
      ft_q        <= '0;
      last_q      <= 1'b0;
    end else begin
      strobe_q   <= 1'b0;
      feed_q     <= (state_q == ST_SCAN);
      feed_idx_q <= scan_idx_q;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            // Every report starts from a clean set of fields.
            slot_q   <= '0;
            closed_q <= 1'b0;
            start_q  <= '0;
            fin_q    <= '0;
            done_q   <= 1'b0;
            tat_q    <= '0;
            wt_q     <= '0;
            ft_q     <= '0;
            last_q   <= 1'b1;
            if (kind_i == KIND_ARRIVE) begin
              strobe_q <= 1'b1;
              if ((burst_length_i == '0) || table_full) begin
                kind_q <= RPT_REJECT;
              end else begin
                kind_q   <= RPT_ACCEPT;
                slot_q   <= SLOT_W'(loaded_q[AW-1:0]);
                loaded_q <= loaded_q + LW'(1);
              end
            end else if (loaded_q == '0) begin
              strobe_q <= 1'b1;
              kind_q   <= RPT_IDLE;
              now_q    <= now_inc;
            end else begin
              scan_idx_q <= '0;
              state_q    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_q <= ST_DRAIN;
          end else begin
            scan_idx_q <= scan_idx_q + AW'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!min_stat.found) begin
            strobe_q <= 1'b1;
            kind_q   <= RPT_IDLE;
            now_q    <= now_inc;
            state_q  <= ST_IDLE;
          end else begin
            // A different pick closes the running segment at the current time.
            if (run_valid_q && (run_slot_q != min_sel)) begin
              strobe_q <= 1'b1;
              kind_q   <= RPT_PREEMPT;
              slot_q   <= SLOT_W'(run_slot_q);
              closed_q <= 1'b1;
              start_q  <= seg_begin_q;
              fin_q    <= now_q;
              last_q   <= 1'b0;
            end
            if (!run_valid_q || (run_slot_q != min_sel)) begin
              seg_begin_q <= now_q;
            end
            run_valid_q <= 1'b1;
            run_slot_q  <= min_sel;
            state_q     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          strobe_q <= 1'b1;
          kind_q   <= RPT_RAN;
          slot_q   <= SLOT_W'(min_sel);
          last_q   <= 1'b1;
          now_q    <= now_inc;
          if (rem_new == '0) begin
            closed_q    <= 1'b1;
            start_q     <= seg_begin_q;
            fin_q       <= now_inc;
            done_q      <= 1'b1;
            tat_q       <= tat;
            wt_q        <= wt;
            ft_q        <= now_inc;
            run_valid_q <= 1'b0;
          end else begin
            closed_q <= 1'b0;
            start_q  <= '0;
            fin_q    <= '0;
            done_q   <= 1'b0;
            tat_q    <= '0;
            wt_q     <= '0;
            ft_q     <= '0;
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign strobe           = strobe_q;
  assign report_kind_o    = kind_q;
  assign job_slot_o       = slot_q;
  assign segment_closed_o = closed_q;
  assign segment_start_o  = start_q;
  assign segment_finish_o = fin_q;
  assign job_done_o       = done_q;
  assign turnaround_o     = tat_q;
  assign waiting_o        = wt_q;
  assign finish_time_o    = ft_q;
  assign last_report_o    = last_q;

  // A preemption report is always followed at once by the report for the new run.
  `SRTF_ASSERT_NEXT(a_preempt_then_run, clk_i, rst_ni,
                    strobe && (report_kind_o == RPT_PREEMPT),
                    strobe && (report_kind_o == RPT_RAN) && last_report_o,
                    "preemption not followed by run report")
  `SRTF_ASSERT(a_loaded_bound, clk_i, rst_ni,
               loaded_q <= LW'(MAX_JOBS),
               "job count beyond table depth")
  `SRTF_ASSERT(a_found_nonzero, clk_i, rst_ni,
               !((state_q == ST_DECIDE) && min_stat.found && (min_stat.best == '0)),
               "picked job has no remaining time")
  `SRTF_ASSERT(a_done_times, clk_i, rst_ni,
               !(strobe && job_done_o) ||
               (segment_closed_o && (finish_time_o == segment_finish_o)),
               "completion times disagree")

endmodule

// ----- hdl/srtf_table.sv -----
// Job table of the SRTF scheduler: remaining time, arrival stamp and burst per slot.
// Depends on srtf_pkg. One write port and one registered read port.
module srtf_table import srtf_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic              clk_i,
  input  tbl_wr_t           wr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [TIME_W-1:0] wr_rem_i,
  input  logic [TIME_W-1:0] wr_arr_i,
  input  logic [TIME_W-1:0] wr_bur_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [TIME_W-1:0] rd_rem_o,
  output logic [TIME_W-1:0] rd_arr_o,
  output logic [TIME_W-1:0] rd_bur_o
);

  logic [TIME_W-1:0] rem_mem [DEPTH];
  logic [TIME_W-1:0] arr_mem [DEPTH];
  logic [TIME_W-1:0] bur_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.job_we || wr_i.rem_we) begin
      rem_mem[wr_addr_i] <= wr_rem_i;
    end
    if (wr_i.job_we) begin
      arr_mem[wr_addr_i] <= wr_arr_i;
      bur_mem[wr_addr_i] <= wr_bur_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_rem_o <= rem_mem[rd_addr_i];
    rd_arr_o <= arr_mem[rd_addr_i];
    rd_bur_o <= bur_mem[rd_addr_i];
  end

endmodule

// ----- hdl/srtf_min_unit.sv -----
// Shared compare unit: keeps the least nonzero remaining time seen and its slot.
// Depends on srtf_pkg. Fed one table entry per cycle by the sequencer.
module srtf_min_unit import srtf_pkg::*; #(
  parameter int unsigned AW = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              feed_i,
  input  logic [TIME_W-1:0] rem_i,
  input  logic [AW-1:0]     idx_i,
  output min_stat_t         stat_o,
  output logic [AW-1:0]     sel_o
);

  min_stat_t     stat_q, stat_d;
  logic [AW-1:0] sel_q, sel_d;

  // Strictly less keeps the lower slot on a tie, as slots arrive in order.
  always_comb begin
    stat_d = stat_q;
    sel_d  = sel_q;
    if (clear_i) begin
      stat_d.found = 1'b0;
    end else if (feed_i && (rem_i != '0) && (!stat_q.found || (rem_i < stat_q.best))) begin
      stat_d.found = 1'b1;
      stat_d.best  = rem_i;
      sel_d        = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
      sel_q  <= '0;
    end else begin
      stat_q <= stat_d;
      sel_q  <= sel_d;
    end
  end

  assign stat_o = stat_q;
  assign sel_o  = sel_q;

endmodule
